// File: sv/ttint_pkg.sv
// Shared types, constants and request/response formats of the trajectory table interpolator.
package ttint_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned SegW = 10;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpQuery  = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_QUERY,
    KIND_CLEAR,
    KIND_NONE
  } kind_e;

  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    logic        [1:0]  op;
    logic        [47:0] sample_time;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [39:0] vel_z;
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic signed [47:0]  out_pos_x;
    logic signed [47:0]  out_pos_y;
    logic signed [47:0]  out_pos_z;
    logic signed [39:0]  out_vel_x;
    logic signed [39:0]  out_vel_y;
    logic signed [39:0]  out_vel_z;
    logic signed [31:0]  out_att_w;
    logic signed [31:0]  out_att_x;
    logic signed [31:0]  out_att_y;
    logic signed [31:0]  out_att_z;
    logic [SegW-1:0]     segment_index;
  } rsp_t;

  typedef struct packed {
    logic [2:0][47:0] pos;
    logic [2:0][39:0] vel;
    logic [3:0][31:0] att;
  } row_t;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    req_t  req;
  } head_t;

endpackage

// File: sv/trajectory_table_interpolator.sv
// Top level of the trajectory table interpolator: request queue front end and table back end.
//
// Requests are taken while busy is low (a two-entry queue holds them) and each one
// gives exactly one result on rsp_o, marked by a single-cycle done_o pulse that the
// receiver must take. Append, clear and rejected requests are answered from the back end's
// idle state once they reach the head of the queue. A query that lands on a table end runs
// one quaternion normalization (5 square steps, 32 square-root steps and, for a nonzero
// norm, four 33-step divides, one bit per cycle). A query between samples takes W
// cursor-walk steps through the single time-table read port, a 30-step alpha divide
// overlapped with the first of three normalizations, 5 dot-product steps and 20 blend
// steps through one shared multiplier pair.
// Table contents are undefined after reset; only appended entries are ever read.
module trajectory_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = ttint_pkg::TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ttint_pkg::req_t  req_i,
  output logic             done_o,
  output ttint_pkg::rsp_t  rsp_o
);

  ttint_pkg::head_t head;
  logic             pop;

  ttint_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .pop_i  (pop),
    .head_o (head)
  );

  ttint_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// File: sv/ttint_front.sv
// Front end: accepts requests, classifies the operation and queues them for the back end.
module ttint_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ttint_pkg::req_t    req_i,
  input  logic               pop_i,
  output ttint_pkg::head_t   head_o
);

  ttint_pkg::req_t  req_q  [2];
  ttint_pkg::kind_e kind_q [2];
  ttint_pkg::kind_e kind_in;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;

  always_comb begin
    unique case (req_i.op)
      ttint_pkg::OpAppend: kind_in = ttint_pkg::KIND_APPEND;
      ttint_pkg::OpQuery:  kind_in = ttint_pkg::KIND_QUERY;
      ttint_pkg::OpClear:  kind_in = ttint_pkg::KIND_CLEAR;
      default:             kind_in = ttint_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    unique case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q]  <= req_i;
      kind_q[wr_ptr_q] <= kind_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.kind  = kind_q[rd_ptr_q];
  assign head_o.req   = req_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("front queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty front queue");
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> cnt_q != 2'd0) else $error("accepted request lost");
`endif

endmodule

// File: sv/ttint_norm.sv
// Quaternion normalizer: sum of squares, bit-serial square root, then serial divides.
module ttint_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ttint_pkg::q30_t   comp_i [4],
  output logic              done_o,
  output ttint_pkg::q30_t   res_o  [4]
);

  typedef enum logic [3:0] {
    N_IDLE = 4'b0001,
    N_SQ   = 4'b0010,
    N_ROOT = 4'b0100,
    N_DIV  = 4'b1000
  } nstate_e;

  nstate_e         state_q, state_d;
  logic            done_q, done_d;
  ttint_pkg::q30_t comp_q [4];
  ttint_pkg::q30_t comp_d [4];
  ttint_pkg::q30_t res_q  [4];
  ttint_pkg::q30_t res_d  [4];
  logic [63:0]     sq_q, sq_d;
  logic [63:0]     s_q, s_d;
  logic [31:0]     root_q, root_d;
  logic [35:0]     rem_q, rem_d;
  logic [35:0]     rem_sh, trial;
  logic [5:0]      cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic [60:0]     num_q, num_d;
  logic [31:0]     drem_q, drem_d;
  logic [32:0]     quo_q, quo_d;
  logic [32:0]     r2;
  logic [31:0]     mg;
  logic [30:0]     capped;
  logic [60:0]     num_ld;

  function automatic logic [31:0] mag32(ttint_pkg::q30_t v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    comp_d  = comp_q;
    res_d   = res_q;
    sq_d    = sq_q;
    s_d     = s_q;
    root_d  = root_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    num_d   = num_q;
    drem_d  = drem_q;
    quo_d   = quo_q;
    mg      = mag32(comp_q[cnt_q[1:0]]);
    rem_sh  = {rem_q[33:0], s_q[63:62]};
    trial   = {2'b00, root_q, 2'b01};
    r2      = {drem_q, num_q[32]};
    capped  = '0;
    num_ld  = '0;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          comp_d  = comp_i;
          done_d  = 1'b0;
          s_d     = '0;
          cnt_d   = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_q != 6'd4) begin
          sq_d = mg * mg;
        end
        if (cnt_q != 6'd0) begin
          s_d = s_q + {2'b00, sq_q[63:2]};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd4) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = N_ROOT;
        end
      end
      N_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[30:0], 1'b0};
        end
        s_d   = {s_q[61:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          if (root_d == '0) begin
            res_d[0] = 32'(ttint_pkg::OneQ30);
            res_d[1] = '0;
            res_d[2] = '0;
            res_d[3] = '0;
            done_d   = 1'b1;
            state_d  = N_IDLE;
          end else begin
            num_ld  = {mag32(comp_q[0]), 29'd0} + 61'(root_d[31:1]);
            num_d   = num_ld;
            drem_d  = 32'(num_ld[60:33]);
            quo_d   = '0;
            idx_d   = 2'd0;
            cnt_d   = '0;
            state_d = N_DIV;
          end
        end
      end
      N_DIV: begin
        if (r2 >= {1'b0, root_q}) begin
          drem_d = 32'(r2 - {1'b0, root_q});
          quo_d  = {quo_q[31:0], 1'b1};
        end else begin
          drem_d = r2[31:0];
          quo_d  = {quo_q[31:0], 1'b0};
        end
        num_d = {num_q[59:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          capped = (quo_d > 33'(ttint_pkg::OneQ30)) ? ttint_pkg::OneQ30 : quo_d[30:0];
          res_d[idx_q] = comp_q[idx_q][31] ? -32'(capped) : 32'(capped);
          if (idx_q == 2'd3) begin
            done_d  = 1'b1;
            state_d = N_IDLE;
          end else begin
            idx_d  = idx_q + 2'd1;
            num_ld = {mag32(comp_q[idx_d]), 29'd0} + 61'(root_q[31:1]);
            num_d  = num_ld;
            drem_d = 32'(num_ld[60:33]);
            quo_d  = '0;
            cnt_d  = '0;
          end
        end
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q <= comp_d;
    res_q  <= res_d;
    sq_q   <= sq_d;
    s_q    <= s_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    drem_q <= drem_d;
    quo_q  <= quo_d;
  end

endmodule

// File: sv/ttint_back.sv
// Back end: sample tables, cursor walk, alpha divide, blends and result assembly.
module ttint_back #(
  parameter int unsigned TABLE_DEPTH = ttint_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttint_pkg::head_t  head_i,
  output logic              pop_o,
  output logic              done_o,
  output ttint_pkg::rsp_t   rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_QFIRST = 17'h00002,
    S_QLAST  = 17'h00004,
    S_FWD    = 17'h00008,
    S_BWD    = 17'h00010,
    S_T1     = 17'h00020,
    S_ROW0   = 17'h00040,
    S_ROW1   = 17'h00080,
    S_ALPHA  = 17'h00100,
    S_N0     = 17'h00200,
    S_N1     = 17'h00400,
    S_DOT    = 17'h00800,
    S_BLEND  = 17'h01000,
    S_BFIN   = 17'h02000,
    S_N2     = 17'h04000,
    S_EROW   = 17'h08000,
    S_EN     = 17'h10000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        cursor_q, cursor_d;
  logic                 done_q, done_d;
  ttint_pkg::rsp_t      rsp_q, rsp_d;

  logic [47:0]          time_mem [TABLE_DEPTH];
  ttint_pkg::row_t      row_mem  [TABLE_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        time_ra, row_ra;
  logic [47:0]          time_rd_q;
  ttint_pkg::row_t      row_rd_q;
  ttint_pkg::row_t      row_wr;

  logic [AW-1:0]        c_q, c_d;
  logic [AW-1:0]        nm1, nm2;
  logic [47:0]          t_q, t_d;
  logic [47:0]          t0_q, t0_d;
  ttint_pkg::row_t      row0_q, row0_d;
  ttint_pkg::row_t      row1_q, row1_d;

  logic [30:0]          alpha_q, alpha_d;
  logic                 dgo_q, dgo_d;
  logic [47:0]          drem_q, drem_d;
  logic [47:0]          dden_q, dden_d;
  logic [4:0]           dcnt_q, dcnt_d;
  logic [48:0]          dr2;

  ttint_pkg::q30_t      q0_q [4];
  ttint_pkg::q30_t      q0_d [4];
  ttint_pkg::q30_t      q1_q [4];
  ttint_pkg::q30_t      q1_d [4];
  logic signed [63:0]   prod_q, prod_d;
  logic signed [63:0]   acc_q, acc_d;
  logic signed [63:0]   acc_sum;
  logic [2:0]           didx_q, didx_d;

  logic [3:0]           bidx_q, bidx_d;
  logic                 bph_q, bph_d;
  logic [62:0]          plo_q, plo_d;
  logic [47:0]          phi_q, phi_d;
  logic                 bneg_q, bneg_d;
  logic signed [49:0]   bbase_q, bbase_d;
  logic signed [49:0]   bv0, bv1, bdiff;
  logic [48:0]          bmag;
  logic [50:0]          rr;
  logic [50:0]          bres;
  logic [1:0]           vi, qi;
  logic [47:0]          op_q [3];
  logic [47:0]          op_d [3];
  logic [39:0]          ov_q [3];
  logic [39:0]          ov_d [3];
  ttint_pkg::q30_t      b_q  [4];
  ttint_pkg::q30_t      b_d  [4];

  logic                 norm_start;
  ttint_pkg::q30_t      norm_in  [4];
  logic                 norm_done;
  ttint_pkg::q30_t      norm_res [4];

  ttint_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .comp_i  (norm_in),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign nm1    = AW'(count_q - CW'(1));
  assign nm2    = AW'(count_q - CW'(2));
  assign pop_o  = (state_q == S_IDLE) && head_i.valid;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign acc_sum = acc_q + prod_q;
  assign dr2    = {drem_q, 1'b0};

  assign row_wr.pos = {head_i.req.pos_z, head_i.req.pos_y, head_i.req.pos_x};
  assign row_wr.vel = {head_i.req.vel_z, head_i.req.vel_y, head_i.req.vel_x};
  assign row_wr.att = {head_i.req.att_z, head_i.req.att_y, head_i.req.att_x, head_i.req.att_w};

  // blend operand select
  always_comb begin
    vi  = 2'(bidx_q - 4'd3);
    qi  = 2'(bidx_q - 4'd6);
    bv0 = '0;
    bv1 = '0;
    if (bidx_q < 4'd3) begin
      bv0 = 50'($signed(row0_q.pos[bidx_q[1:0]]));
      bv1 = 50'($signed(row1_q.pos[bidx_q[1:0]]));
    end else if (bidx_q < 4'd6) begin
      bv0 = 50'($signed(row0_q.vel[vi]));
      bv1 = 50'($signed(row1_q.vel[vi]));
    end else begin
      bv0 = 50'(q0_q[qi]);
      bv1 = 50'(q1_q[qi]);
    end
    bdiff = bv1 - bv0;
    bmag  = bdiff[49] ? 49'(-bdiff) : 49'(bdiff);
    rr    = 51'({phi_q, 2'b00}) + 51'((plo_q + 63'(32'h2000_0000)) >> 30);
    bres  = 51'(bbase_q) + (bneg_q ? (51'(0) - rr) : rr);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cursor_d   = cursor_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    time_ra    = '0;
    row_ra     = '0;
    c_d        = c_q;
    t_d        = t_q;
    t0_d       = t0_q;
    row0_d     = row0_q;
    row1_d     = row1_q;
    alpha_d    = alpha_q;
    dgo_d      = dgo_q;
    drem_d     = drem_q;
    dden_d     = dden_q;
    dcnt_d     = dcnt_q;
    q0_d       = q0_q;
    q1_d       = q1_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    didx_d     = didx_q;
    bidx_d     = bidx_q;
    bph_d      = bph_q;
    plo_d      = plo_q;
    phi_d      = phi_q;
    bneg_d     = bneg_q;
    bbase_d    = bbase_q;
    op_d       = op_q;
    ov_d       = ov_q;
    b_d        = b_q;
    norm_start = 1'b0;
    norm_in    = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.kind)
            ttint_pkg::KIND_APPEND: begin
              rsp_d  = '0;
              done_d = 1'b1;
              if (count_q < CW'(TABLE_DEPTH)) begin
                mem_we   = 1'b1;
                count_d  = count_q + CW'(1);
                rsp_d.ok = 1'b1;
              end
            end
            ttint_pkg::KIND_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
              rsp_d    = '0;
              rsp_d.ok = 1'b1;
              done_d   = 1'b1;
            end
            ttint_pkg::KIND_QUERY: begin
              t_d = head_i.req.sample_time;
              if (count_q == '0) begin
                rsp_d  = '0;
                done_d = 1'b1;
              end else begin
                time_ra = '0;
                state_d = S_QFIRST;
              end
            end
            default: begin
              rsp_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_QFIRST: begin
        if (count_q == CW'(1) || t_q <= time_rd_q) begin
          cursor_d = '0;
          row_ra   = '0;
          state_d  = S_EROW;
        end else begin
          time_ra = nm1;
          state_d = S_QLAST;
        end
      end
      S_QLAST: begin
        if (t_q >= time_rd_q) begin
          cursor_d = nm2;
          row_ra   = nm1;
          state_d  = S_EROW;
        end else begin
          c_d     = (cursor_q > nm2) ? nm2 : cursor_q;
          time_ra = c_d + AW'(1);
          state_d = S_FWD;
        end
      end
      S_FWD: begin
        if ((CW'(c_q) + CW'(1) < count_q - CW'(1)) && (time_rd_q < t_q)) begin
          c_d     = c_q + AW'(1);
          time_ra = c_q + AW'(1) + AW'(1);
        end else begin
          time_ra = c_q;
          state_d = S_BWD;
        end
      end
      S_BWD: begin
        if ((c_q != '0) && (time_rd_q > t_q)) begin
          c_d     = c_q - AW'(1);
          time_ra = c_q - AW'(1);
        end else begin
          t0_d     = time_rd_q;
          cursor_d = c_q;
          time_ra  = c_q + AW'(1);
          state_d  = S_T1;
        end
      end
      S_T1: begin
        alpha_d = '0;
        dgo_d   = 1'b0;
        dcnt_d  = '0;
        if (time_rd_q > t0_q) begin
          if (t_q <= t0_q) begin
            alpha_d = '0;
          end else if (t_q >= time_rd_q) begin
            alpha_d = ttint_pkg::OneQ30;
          end else begin
            dgo_d  = 1'b1;
            drem_d = t_q - t0_q;
            dden_d = time_rd_q - t0_q;
          end
        end
        row_ra  = c_q;
        state_d = S_ROW0;
      end
      S_ROW0: begin
        row0_d  = row_rd_q;
        row_ra  = c_q + AW'(1);
        state_d = S_ROW1;
      end
      S_ROW1: begin
        row1_d     = row_rd_q;
        norm_start = 1'b1;
        for (int k = 0; k < 4; k++) begin
          norm_in[k] = $signed(row0_q.att[k]);
        end
        state_d = S_ALPHA;
      end
      S_ALPHA: begin
        if (dgo_q) begin
          if (dr2 >= {1'b0, dden_q}) begin
            drem_d  = 48'(dr2 - {1'b0, dden_q});
            alpha_d = {alpha_q[29:0], 1'b1};
          end else begin
            drem_d  = dr2[47:0];
            alpha_d = {alpha_q[29:0], 1'b0};
          end
          dcnt_d = dcnt_q + 5'd1;
          if (dcnt_q == 5'd29) begin
            state_d = S_N0;
          end
        end else begin
          state_d = S_N0;
        end
      end
      S_N0: begin
        if (norm_done) begin
          q0_d       = norm_res;
          norm_start = 1'b1;
          for (int k = 0; k < 4; k++) begin
            norm_in[k] = $signed(row1_q.att[k]);
          end
          state_d = S_N1;
        end
      end
      S_N1: begin
        if (norm_done) begin
          q1_d    = norm_res;
          didx_d  = '0;
          acc_d   = '0;
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        if (didx_q != 3'd4) begin
          prod_d = q0_q[didx_q[1:0]] * q1_q[didx_q[1:0]];
        end
        if (didx_q != 3'd0) begin
          acc_d = acc_sum;
        end
        didx_d = didx_q + 3'd1;
        if (didx_q == 3'd4) begin
          if (acc_sum[63]) begin
            for (int k = 0; k < 4; k++) begin
              q1_d[k] = -q1_q[k];
            end
          end
          bidx_d  = '0;
          bph_d   = 1'b0;
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        if (!bph_q) begin
          plo_d   = bmag[31:0] * alpha_q;
          phi_d   = bmag[48:32] * alpha_q;
          bneg_d  = bdiff[49];
          bbase_d = bv0;
          bph_d   = 1'b1;
        end else begin
          bph_d = 1'b0;
          if (bidx_q < 4'd3) begin
            op_d[bidx_q[1:0]] = bres[47:0];
          end else if (bidx_q < 4'd6) begin
            ov_d[vi] = bres[39:0];
          end else begin
            b_d[qi] = $signed(bres[31:0]);
          end
          bidx_d = bidx_q + 4'd1;
          if (bidx_q == 4'd9) begin
            state_d = S_BFIN;
          end
        end
      end
      S_BFIN: begin
        norm_start = 1'b1;
        norm_in    = b_q;
        state_d    = S_N2;
      end
      S_N2: begin
        if (norm_done) begin
          rsp_d.ok            = 1'b1;
          rsp_d.out_pos_x     = op_q[0];
          rsp_d.out_pos_y     = op_q[1];
          rsp_d.out_pos_z     = op_q[2];
          rsp_d.out_vel_x     = ov_q[0];
          rsp_d.out_vel_y     = ov_q[1];
          rsp_d.out_vel_z     = ov_q[2];
          rsp_d.out_att_w     = norm_res[0];
          rsp_d.out_att_x     = norm_res[1];
          rsp_d.out_att_y     = norm_res[2];
          rsp_d.out_att_z     = norm_res[3];
          rsp_d.segment_index = ttint_pkg::SegW'(cursor_q);
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_EROW: begin
        row0_d     = row_rd_q;
        norm_start = 1'b1;
        for (int k = 0; k < 4; k++) begin
          norm_in[k] = $signed(row_rd_q.att[k]);
        end
        state_d = S_EN;
      end
      S_EN: begin
        if (norm_done) begin
          rsp_d.ok            = 1'b1;
          rsp_d.out_pos_x     = row0_q.pos[0];
          rsp_d.out_pos_y     = row0_q.pos[1];
          rsp_d.out_pos_z     = row0_q.pos[2];
          rsp_d.out_vel_x     = row0_q.vel[0];
          rsp_d.out_vel_y     = row0_q.vel[1];
          rsp_d.out_vel_z     = row0_q.vel[2];
          rsp_d.out_att_w     = norm_res[0];
          rsp_d.out_att_x     = norm_res[1];
          rsp_d.out_att_y     = norm_res[2];
          rsp_d.out_att_z     = norm_res[3];
          rsp_d.segment_index = ttint_pkg::SegW'(cursor_q);
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[count_q[AW-1:0]] <= head_i.req.sample_time;
      row_mem[count_q[AW-1:0]]  <= row_wr;
    end
    time_rd_q <= time_mem[time_ra];
    row_rd_q  <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
      dcnt_q   <= '0;
      didx_q   <= '0;
      bidx_q   <= '0;
      bph_q    <= 1'b0;
      dgo_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
      dcnt_q   <= dcnt_d;
      didx_q   <= didx_d;
      bidx_q   <= bidx_d;
      bph_q    <= bph_d;
      dgo_q    <= dgo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    c_q     <= c_d;
    t_q     <= t_d;
    t0_q    <= t0_d;
    row0_q  <= row0_d;
    row1_q  <= row1_d;
    alpha_q <= alpha_d;
    drem_q  <= drem_d;
    dden_q  <= dden_d;
    q0_q    <= q0_d;
    q1_q    <= q1_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    plo_q   <= plo_d;
    phi_q   <= phi_d;
    bneg_q  <= bneg_d;
    bbase_q <= bbase_d;
    op_q    <= op_d;
    ov_q    <= ov_d;
    b_q     <= b_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count beyond table depth");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !rsp_q.ok |-> rsp_q.out_pos_x == '0 && rsp_q.out_att_w == '0 &&
    rsp_q.segment_index == '0) else $error("failed request carries pose data");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.kind == ttint_pkg::KIND_CLEAR |=> count_q == '0 && cursor_q == '0)
    else $error("clear did not empty table");
  a_norm_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !norm_start) else $error("normalizer started while taking a request");
`endif

endmodule

// File: sim/trajectory_table_interpolator_test.sv
// Self-checking testbench of the trajectory table interpolator: directed table, then random sessions.
module trajectory_table_interpolator_test;

  localparam int Depth = ttint_pkg::TableDepthDefault;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic            done_o;
  ttint_pkg::req_t req_i;
  ttint_pkg::rsp_t rsp_o;

  trajectory_table_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // table mirror
  logic [47:0]     tbl_time [Depth];
  ttint_pkg::row_t tbl_row  [Depth];
  int unsigned     tbl_count;
  int unsigned     tbl_cursor;

  ttint_pkg::rsp_t pose_q [$];
  int              fail_count;
  int              burst_left;

  typedef struct {
    ttint_pkg::req_t req;
    logic            typed;
    ttint_pkg::rsp_t pose;
  } step_t;

  step_t steps [$];

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint blend_step(longint d, logic [63:0] a);
    logic [63:0] m;
    logic [63:0] r;
    m = mag64(d);
    r = (((m >> 32) * a) << 2) + (((m & 64'hFFFF_FFFF) * a + (64'd1 << 29)) >> 30);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b2;
    res = 0;
    b2 = 64'd1 << 62;
    while (b2 > x) b2 = b2 >> 2;
    while (b2 != 0) begin
      if (x >= res + b2) begin
        x = x - (res + b2);
        res = (res >> 1) + b2;
      end else begin
        res = res >> 1;
      end
      b2 = b2 >> 2;
    end
    return res;
  endfunction

  function automatic void unit_quat(input longint qi [4], output longint qo [4]);
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] q;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m = mag64(qi[i]);
      s = s + ((m * m) >> 2);
    end
    r = int_sqrt(s);
    if (r == 0) begin
      qo[0] = longint'(1) << 30;
      qo[1] = 0;
      qo[2] = 0;
      qo[3] = 0;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      q = ((mag64(qi[i]) << 29) + (r >> 1)) / r;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      qo[i] = (qi[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic [63:0] alpha_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = num;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic void row_quat(int unsigned k, output longint qo [4]);
    longint qi [4];
    for (int j = 0; j < 4; j++) qi[j] = longint'($signed(tbl_row[k].att[3-j]));
    unit_quat(qi, qo);
  endfunction

  function automatic ttint_pkg::rsp_t sample_pose(int unsigned k);
    ttint_pkg::rsp_t p;
    longint          q [4];
    p = '0;
    p.ok = 1'b1;
    p.out_pos_x = tbl_row[k].pos[2];
    p.out_pos_y = tbl_row[k].pos[1];
    p.out_pos_z = tbl_row[k].pos[0];
    p.out_vel_x = tbl_row[k].vel[2];
    p.out_vel_y = tbl_row[k].vel[1];
    p.out_vel_z = tbl_row[k].vel[0];
    row_quat(k, q);
    p.out_att_w = q[0][31:0];
    p.out_att_x = q[1][31:0];
    p.out_att_y = q[2][31:0];
    p.out_att_z = q[3][31:0];
    return p;
  endfunction

  function automatic ttint_pkg::rsp_t interp_pose(logic [47:0] t);
    ttint_pkg::rsp_t p;
    int unsigned     n;
    int unsigned     c;
    logic [63:0]     t0;
    logic [63:0]     t1;
    logic [63:0]     a;
    longint          q0 [4];
    longint          q1 [4];
    longint          bq [4];
    longint          qo [4];
    longint          dot;
    longint          v [6];
    p = '0;
    n = tbl_count;
    if (n == 0) return p;
    if (n == 1 || t <= tbl_time[0]) begin
      tbl_cursor = 0;
      p = sample_pose(0);
    end else if (t >= tbl_time[n-1]) begin
      tbl_cursor = n - 2;
      p = sample_pose(n - 1);
    end else begin
      c = tbl_cursor;
      if (c > n - 2) c = n - 2;
      while (c + 1 < n - 1 && tbl_time[c+1] < t) c++;
      while (c > 0 && tbl_time[c] > t) c--;
      tbl_cursor = c;
      t0 = tbl_time[c];
      t1 = tbl_time[c+1];
      a = 0;
      if (t1 > t0) begin
        if (t <= t0) a = 0;
        else if (t >= t1) a = 64'd1 << 30;
        else a = alpha_div(t - t0, t1 - t0);
      end
      for (int j = 0; j < 3; j++) begin
        v[j] = longint'($signed(tbl_row[c].pos[2-j]));
        v[j] = v[j] + blend_step(longint'($signed(tbl_row[c+1].pos[2-j])) - v[j], a);
        v[3+j] = longint'($signed(tbl_row[c].vel[2-j]));
        v[3+j] = v[3+j] + blend_step(longint'($signed(tbl_row[c+1].vel[2-j])) - v[3+j], a);
      end
      p.ok = 1'b1;
      p.out_pos_x = v[0][47:0];
      p.out_pos_y = v[1][47:0];
      p.out_pos_z = v[2][47:0];
      p.out_vel_x = v[3][39:0];
      p.out_vel_y = v[4][39:0];
      p.out_vel_z = v[5][39:0];
      row_quat(c, q0);
      row_quat(c + 1, q1);
      dot = 0;
      for (int j = 0; j < 4; j++) dot += q0[j] * q1[j];
      if (dot < 0) for (int j = 0; j < 4; j++) q1[j] = -q1[j];
      for (int j = 0; j < 4; j++) bq[j] = q0[j] + blend_step(q1[j] - q0[j], a);
      unit_quat(bq, qo);
      p.out_att_w = qo[0][31:0];
      p.out_att_x = qo[1][31:0];
      p.out_att_y = qo[2][31:0];
      p.out_att_z = qo[3][31:0];
    end
    p.segment_index = tbl_cursor[ttint_pkg::SegW-1:0];
    return p;
  endfunction

  function automatic ttint_pkg::rsp_t predict_pose(ttint_pkg::req_t r);
    ttint_pkg::rsp_t p;
    p = '0;
    case (r.op)
      ttint_pkg::OpAppend: begin
        if (tbl_count < Depth) begin
          tbl_time[tbl_count] = r.sample_time;
          tbl_row[tbl_count].pos = {r.pos_x, r.pos_y, r.pos_z};
          tbl_row[tbl_count].vel = {r.vel_x, r.vel_y, r.vel_z};
          tbl_row[tbl_count].att = {r.att_w, r.att_x, r.att_y, r.att_z};
          tbl_count++;
          p.ok = 1'b1;
        end
      end
      ttint_pkg::OpQuery: begin
        p = interp_pose(r.sample_time);
      end
      ttint_pkg::OpClear: begin
        tbl_count = 0;
        tbl_cursor = 0;
        p.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic check_pose(ttint_pkg::rsp_t got, ttint_pkg::rsp_t want);
    if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
    if (got.out_pos_x !== want.out_pos_x) begin
      report_mismatch("pos_x", 64'(got.out_pos_x), 64'(want.out_pos_x));
    end
    if (got.out_pos_y !== want.out_pos_y) begin
      report_mismatch("pos_y", 64'(got.out_pos_y), 64'(want.out_pos_y));
    end
    if (got.out_pos_z !== want.out_pos_z) begin
      report_mismatch("pos_z", 64'(got.out_pos_z), 64'(want.out_pos_z));
    end
    if (got.out_vel_x !== want.out_vel_x) begin
      report_mismatch("vel_x", 64'(got.out_vel_x), 64'(want.out_vel_x));
    end
    if (got.out_vel_y !== want.out_vel_y) begin
      report_mismatch("vel_y", 64'(got.out_vel_y), 64'(want.out_vel_y));
    end
    if (got.out_vel_z !== want.out_vel_z) begin
      report_mismatch("vel_z", 64'(got.out_vel_z), 64'(want.out_vel_z));
    end
    if (got.out_att_w !== want.out_att_w) begin
      report_mismatch("att_w", 64'(got.out_att_w), 64'(want.out_att_w));
    end
    if (got.out_att_x !== want.out_att_x) begin
      report_mismatch("att_x", 64'(got.out_att_x), 64'(want.out_att_x));
    end
    if (got.out_att_y !== want.out_att_y) begin
      report_mismatch("att_y", 64'(got.out_att_y), 64'(want.out_att_y));
    end
    if (got.out_att_z !== want.out_att_z) begin
      report_mismatch("att_z", 64'(got.out_att_z), 64'(want.out_att_z));
    end
    if (got.segment_index !== want.segment_index) begin
      report_mismatch("segment_index", 64'(got.segment_index), 64'(want.segment_index));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pose_q.size() == 0) begin
        report_mismatch("result with none pending", 64'(rsp_o.ok), 64'd0);
      end else begin
        check_pose(rsp_o, pose_q.pop_front());
      end
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom} >> 16);
  endfunction

  function automatic logic [31:0] rand_att();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 2000)) - 1000);
      1: return 32'(1 << 30);
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic ttint_pkg::req_t mk_req(logic [1:0] op, logic [47:0] t);
    ttint_pkg::req_t r;
    r.op = op;
    r.sample_time = t;
    r.pos_x = rand48();
    r.pos_y = rand48();
    r.pos_z = rand48();
    r.vel_x = 40'({$urandom, $urandom} >> 24);
    r.vel_y = 40'({$urandom, $urandom} >> 24);
    r.vel_z = 40'({$urandom, $urandom} >> 24);
    r.att_w = rand_att();
    r.att_x = rand_att();
    r.att_y = rand_att();
    r.att_z = rand_att();
    return r;
  endfunction

  // hold start until the request is taken; keep start high across back-to-back requests
  task automatic send_request(ttint_pkg::req_t r, logic typed, ttint_pkg::rsp_t pose);
    ttint_pkg::rsp_t p;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = predict_pose(r);
    pose_q.push_back(typed ? pose : p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      req_i <= mk_req(2'($urandom), rand48());
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic send(ttint_pkg::req_t r);
    send_request(r, 1'b0, '0);
  endtask

  initial begin
    step_t           s;
    ttint_pkg::rsp_t ok_only;
    ttint_pkg::req_t r;
    logic [47:0]     t;
    logic [47:0]     t_first;
    int              n;
    int              issued;

    fail_count = 0;
    burst_left = 0;
    tbl_count = 0;
    tbl_cursor = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    ok_only = '0;
    ok_only.ok = 1'b1;

    s.typed = 1'b1;
    s.pose = '0;
    s.req = mk_req(ttint_pkg::OpQuery, 48'd0);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpUnused, rand48());
    steps.push_back(s);
    s.pose = ok_only;
    s.req = mk_req(ttint_pkg::OpAppend, 48'd0);
    s.req.pos_x = 48'sh7FFF_FFFF_FFFF;
    s.req.pos_y = 48'sh8000_0000_0000;
    s.req.vel_x = 40'sh7F_FFFF_FFFF;
    s.req.vel_y = 40'sh80_0000_0000;
    s.req.att_w = 32'h8000_0000;
    s.req.att_x = 32'h7FFF_FFFF;
    s.req.att_y = 32'h8000_0000;
    s.req.att_z = 32'h7FFF_FFFF;
    steps.push_back(s);
    s.typed = 1'b0;
    s.req = mk_req(ttint_pkg::OpQuery, 48'hFFFF_FFFF_FFFF);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpAppend, 48'hFFFF_FFFF_FFFF);
    s.req.pos_x = 48'sh8000_0000_0000;
    s.req.pos_y = 48'sh7FFF_FFFF_FFFF;
    s.req.vel_x = 40'sh80_0000_0000;
    s.req.vel_y = 40'sh7F_FFFF_FFFF;
    s.req.att_w = 32'd0;
    s.req.att_x = 32'd0;
    s.req.att_y = 32'd0;
    s.req.att_z = 32'd0;
    steps.push_back(s);
    foreach (t_first[i]) begin
      if (i < 6) begin
        s.req = mk_req(ttint_pkg::OpQuery, (48'd1 << (8 * i + 2)) - 48'd1);
        steps.push_back(s);
      end
    end
    s.req = mk_req(ttint_pkg::OpQuery, 48'hFFFF_FFFF_FFFE);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpQuery, 48'h8000_0000_0000);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpAppend, 48'hFFFF_FFFF_FFFF);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpAppend, 48'h0000_0000_1000);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpQuery, 48'h0000_0000_0800);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpQuery, 48'h8000_0000_0000);
    steps.push_back(s);
    s.req = mk_req(ttint_pkg::OpQuery, 48'd0);
    steps.push_back(s);
    s.typed = 1'b1;
    s.pose = ok_only;
    s.req = mk_req(ttint_pkg::OpClear, rand48());
    steps.push_back(s);
    s.pose = '0;
    s.req = mk_req(ttint_pkg::OpQuery, rand48());
    steps.push_back(s);
    s.pose = ok_only;
    s.req = mk_req(ttint_pkg::OpAppend, 48'd500);
    steps.push_back(s);
    s.typed = 1'b0;
    s.req = mk_req(ttint_pkg::OpQuery, 48'd10);
    steps.push_back(s);

    foreach (steps[i]) send_request(steps[i].req, steps[i].typed, steps[i].pose);

    // fill the table to the top, then push one more append
    t = 48'd1000;
    while (tbl_count < Depth) begin
      t = t + 48'($urandom_range(0, 300));
      send(mk_req(ttint_pkg::OpAppend, t));
    end
    r = mk_req(ttint_pkg::OpAppend, t + 48'd1);
    s.pose = '0;
    send_request(r, 1'b1, s.pose);
    send(mk_req(ttint_pkg::OpQuery, t - 48'd5));
    send(mk_req(ttint_pkg::OpQuery, 48'd1500));
    send(mk_req(ttint_pkg::OpQuery, 48'd1000 + 48'(tbl_time[Depth/2] - 48'd1000) + 48'd1));
    send(mk_req(ttint_pkg::OpQuery, 48'd1200));

    // drain before the random sessions
    start <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);

    issued = 0;
    while (issued < 300) begin
      send(mk_req(ttint_pkg::OpClear, rand48()));
      issued++;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      t_first = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom);
      t = t_first;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          r = mk_req(ttint_pkg::OpAppend, rand48());
        end else begin
          t = t + 48'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom);
          r = mk_req(ttint_pkg::OpAppend, t);
        end
        send(r);
        issued++;
      end
      repeat ($urandom_range(2, 10)) begin
        case ($urandom_range(0, 9))
          0: r = mk_req(ttint_pkg::OpQuery, t_first - 48'($urandom_range(0, 3)));
          1: r = mk_req(ttint_pkg::OpQuery, t + 48'($urandom_range(0, 3)));
          2: r = mk_req(ttint_pkg::OpQuery, tbl_time[$urandom_range(0, tbl_count - 1)]);
          3: r = mk_req(ttint_pkg::OpQuery, rand48());
          4: r = mk_req(ttint_pkg::OpUnused, rand48());
          default: begin
            r = mk_req(ttint_pkg::OpQuery,
                       t_first + 48'($urandom) % (t - t_first + 48'd1));
          end
        endcase
        send(r);
        issued++;
      end
    end

    start <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
